// ===== rtl/dual_text_display_shadow_refresh_core_assert.svh =====
// Assertion macros for the dual text display shadow refresh core.
// Used by files that write concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef DUAL_TEXT_DISPLAY_SHADOW_REFRESH_CORE_ASSERT_SVH
`define DUAL_TEXT_DISPLAY_SHADOW_REFRESH_CORE_ASSERT_SVH

// Property checked at every rising clock edge outside of reset.
`define DTDSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside of reset.
`define DTDSR_ASSERT_NEVER(name, cond, msg) \
  `DTDSR_ASSERT(name, !(cond), msg)

`endif

// ===== rtl/dtdsr_pkg.sv =====
// Package of the dual text display shadow refresh core: sizes, codes, types and helpers.
// Used by every module of the core; depends on nothing.
package dtdsr_pkg;

  // Bytes kept per emulated display line and symbols scanned per line.
  localparam int LineBytes      = 64;
  localparam int ScannedSymbols = 10;

  // Five columns form one symbol; each line has this many groups.
  localparam int SymbolCols     = 5;
  localparam int GroupsPerLine  = (LineBytes + SymbolCols - 1) / SymbolCols;
  localparam int NumLines       = 4;
  localparam int NumRows        = NumLines * GroupsPerLine;
  localparam int RowW           = $clog2(NumRows);

  localparam int ColW           = 6;
  localparam int LaneW          = 3;
  localparam int SymW           = 4;
  localparam int PanelColW      = 7;
  localparam int PageW          = 2;

  // Panel placement: symbol pitch and the offset of display 0.
  localparam int SymbolPitch    = 6;
  localparam int Display0Offset = 60;

  // Command byte layout.
  localparam int CmdValidBit    = 7;
  localparam int CmdLineBit     = 6;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2
  } op_e;

  // One stored symbol: five column bytes, byte 0 first.
  typedef logic [SymbolCols-1:0][7:0] row_t;

  // Work record handed from the front to the back through the queue.
  typedef struct packed {
    logic            wr_en;
    logic [RowW-1:0] wr_row;
    logic [LaneW-1:0] wr_lane;
    logic [7:0]      wr_byte;
    logic            scan_ok;
    logic [RowW-1:0] scan_row;
    logic [1:0]      scan_line;
    logic [SymW-1:0] scan_sym;
    logic            accepts;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Column divided by five as a multiply by 13/64; exact for all 6-bit columns.
  function automatic logic [SymW-1:0] group_of(input logic [ColW-1:0] col);
    logic [9:0] prod;
    prod = {4'b0, col} * 10'd13;
    return prod[9:6];
  endfunction

  function automatic logic [LaneW-1:0] lane_of(input logic [ColW-1:0] col,
                                              input logic [SymW-1:0] grp);
    logic [ColW-1:0] base;
    base = ColW'(int'(grp) * SymbolCols);
    return LaneW'(col - base);
  endfunction

  function automatic logic [RowW-1:0] row_of(input logic [1:0] ln,
                                            input logic [SymW-1:0] grp);
    return RowW'(int'(ln) * GroupsPerLine + int'(grp));
  endfunction

  function automatic logic [PanelColW-1:0] column_of(input logic [SymW-1:0] sym,
                                                    input logic [1:0] ln);
    return PanelColW'(int'(sym) * SymbolPitch + (ln[1] ? 0 : Display0Offset));
  endfunction

endpackage

// ===== rtl/dtdsr_front.sv =====
// Front of the dual text display shadow refresh core: accepts bus items, keeps the
// cursors and the refresh scan position, and issues work records. Depends on dtdsr_pkg.
module dtdsr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,  // [7:0] bus_byte, [8] panel_accepts
  input  logic [2:0]          s_axis_tuser_i,  // [1:0] op, [2] display_sel
  input  dtdsr_pkg::fifo_stat_t fifo_stat_i,
  output logic                push_o,
  output dtdsr_pkg::work_t    work_o
);

  logic [1:0]                     line_q, line_d;
  logic [1:0][dtdsr_pkg::ColW-1:0] cur_q, cur_d;
  logic [dtdsr_pkg::SymW-1:0]     sym_q, sym_d;
  logic [1:0]                     sline_q, sline_d;

  logic                           accept;
  logic [1:0]                     op;
  logic                           sel;
  logic [7:0]                     byte_in;
  logic [dtdsr_pkg::ColW-1:0]     col;
  logic [dtdsr_pkg::SymW-1:0]     grp;
  logic                           wr_en;

  assign op      = s_axis_tuser_i[1:0];
  assign sel     = s_axis_tuser_i[2];
  assign byte_in = s_axis_tdata_i[7:0];

  assign s_axis_tready_o = !fifo_stat_i.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept;

  assign col = cur_q[sel];
  assign grp = dtdsr_pkg::group_of(col);

  always_comb begin
    line_d = line_q;
    cur_d  = cur_q;
    wr_en  = 1'b0;
    unique case (op)
      dtdsr_pkg::OP_CMD: begin
        if (byte_in[dtdsr_pkg::CmdValidBit]) begin
          line_d[sel] = byte_in[dtdsr_pkg::CmdLineBit];
          cur_d[sel]  = byte_in[dtdsr_pkg::ColW-1:0];
        end
      end
      dtdsr_pkg::OP_DATA: begin
        // Bytes past the end of the line are dropped, the cursor still moves.
        wr_en      = {1'b0, col} < (dtdsr_pkg::ColW+1)'(dtdsr_pkg::LineBytes);
        cur_d[sel] = col + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sym_d   = sym_q + 1'b1;
    sline_d = sline_q;
    if (sym_q == dtdsr_pkg::SymW'(dtdsr_pkg::ScannedSymbols - 1)) begin
      sym_d   = '0;
      sline_d = sline_q + 1'b1;
    end
  end

  always_comb begin
    work_o.wr_en     = wr_en;
    work_o.wr_row    = dtdsr_pkg::row_of({sel, line_q[sel]}, grp);
    work_o.wr_lane   = dtdsr_pkg::lane_of(col, grp);
    work_o.wr_byte   = byte_in;
    work_o.scan_ok   = sym_q < dtdsr_pkg::SymW'(dtdsr_pkg::GroupsPerLine);
    work_o.scan_row  = dtdsr_pkg::row_of(sline_q, sym_q);
    work_o.scan_line = sline_q;
    work_o.scan_sym  = sym_q;
    work_o.accepts   = s_axis_tdata_i[8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      cur_q   <= '0;
      sym_q   <= '0;
      sline_q <= '0;
    end else if (accept) begin
      line_q  <= line_d;
      cur_q   <= cur_d;
      sym_q   <= sym_d;
      sline_q <= sline_d;
    end
  end

endmodule

// ===== rtl/dtdsr_fifo.sv =====
// Two-entry queue of work records between the front and the back of the core.
// Depends on dtdsr_pkg.
module dtdsr_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dtdsr_pkg::work_t      push_data_i,
  input  logic                  pop_i,
  output dtdsr_pkg::work_t      head_o,
  output dtdsr_pkg::fifo_stat_t stat_o
);

  dtdsr_pkg::work_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = count_q == 2'd2;
  assign stat_o.empty = count_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/dtdsr_back.sv =====
// Back of the dual text display shadow refresh core: symbol store, dirty marks,
// glyph lookup and the output register. Depends on dtdsr_pkg.
module dtdsr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dtdsr_pkg::work_t      head_i,
  input  dtdsr_pkg::fifo_stat_t fifo_stat_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [55:0]           m_axis_tdata_o,
  output logic [0:0]            m_axis_tuser_o
);

  // Symbol store: one row per symbol, read at the write row and the scan row.
  dtdsr_pkg::row_t mem_q [dtdsr_pkg::NumRows];
  logic [dtdsr_pkg::NumRows-1:0] row_vld_q;
  logic [dtdsr_pkg::NumRows-1:0] dirty_q, dirty_d;

  // Execute stage.
  logic             e_valid_q;
  dtdsr_pkg::work_t e_q;
  dtdsr_pkg::row_t  rd_w_q, rd_s_q;
  logic             vld_w_q, vld_s_q;

  // Last row written, to cover a read that raced the write.
  logic                       fwd_valid_q;
  logic [dtdsr_pkg::RowW-1:0] fwd_row_q;
  dtdsr_pkg::row_t            fwd_data_q;

  // Output register.
  logic        o_valid_q;
  logic        o_put_q;
  logic [48:0] o_data_q;

  logic            e_adv, e_ready;
  dtdsr_pkg::row_t old_w, new_w, old_s, scan_data;
  logic            changed, same_row, hit;

  assign e_adv   = e_valid_q && (!o_valid_q || m_axis_tready_i);
  assign e_ready = !e_valid_q || e_adv;
  assign pop_o   = !fifo_stat_i.empty && e_ready;

  always_comb begin
    if (fwd_valid_q && fwd_row_q == e_q.wr_row) begin
      old_w = fwd_data_q;
    end else begin
      old_w = vld_w_q ? rd_w_q : '0;
    end
    if (fwd_valid_q && fwd_row_q == e_q.scan_row) begin
      old_s = fwd_data_q;
    end else begin
      old_s = vld_s_q ? rd_s_q : '0;
    end
    new_w                = old_w;
    new_w[e_q.wr_lane]   = e_q.wr_byte;
    changed              = e_q.wr_en && (old_w[e_q.wr_lane] != e_q.wr_byte);
    same_row             = e_q.wr_row == e_q.scan_row;
    scan_data            = (e_q.wr_en && same_row) ? new_w : old_s;
    // The scan sees a mark set by the write of the same item.
    hit = e_q.scan_ok && (dirty_q[e_q.scan_row] || (changed && same_row));
  end

  // A write that changes a byte sets its mark; an accepted glyph write clears
  // the scanned mark, and the clear wins when both hit the same row.
  always_comb begin
    dirty_d = dirty_q;
    if (e_adv) begin
      if (changed) begin
        dirty_d[e_q.wr_row] = 1'b1;
      end
      if (hit && e_q.accepts) begin
        dirty_d[e_q.scan_row] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_adv && e_q.wr_en) begin
      mem_q[e_q.wr_row] <= new_w;
    end
    if (pop_o) begin
      rd_w_q <= mem_q[head_i.wr_row];
      rd_s_q <= mem_q[head_i.scan_row];
      vld_w_q <= row_vld_q[head_i.wr_row];
      vld_s_q <= row_vld_q[head_i.scan_row];
      e_q     <= head_i;
    end
    if (e_adv && e_q.wr_en) begin
      fwd_row_q  <= e_q.wr_row;
      fwd_data_q <= new_w;
    end
    if (e_adv) begin
      o_put_q  <= hit;
      o_data_q <= hit ? {scan_data[4], scan_data[3], scan_data[2], scan_data[1], scan_data[0],
                         dtdsr_pkg::PageW'({1'b0, e_q.scan_line[0]} + 2'd1),
                         dtdsr_pkg::column_of(e_q.scan_sym, e_q.scan_line)} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      dirty_q     <= '1;
      e_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid_q <= pop_o;
      end
      if (e_adv) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
      if (e_adv && e_q.wr_en) begin
        row_vld_q[e_q.wr_row] <= 1'b1;
        fwd_valid_q           <= 1'b1;
      end
      dirty_q <= dirty_d;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tuser_o  = o_put_q;
  assign m_axis_tdata_o  = {7'b0, o_data_q};

endmodule

// ===== rtl/dual_text_display_shadow_refresh_core.sv =====
// Top level of the dual text display shadow refresh core.
// Depends on dtdsr_pkg, dtdsr_front, dtdsr_fifo, dtdsr_back and the assertion header.
//
// This core shadows two emulated two-line text displays and mirrors them onto a
// graphic panel. Every input transfer carries at most one bus access (a command
// byte that moves a display's cursor, or a data byte stored at the cursor) and
// the panel's accept flag, and it yields exactly one output transfer: either a
// glyph write of one dirty five-column symbol with its panel column and page, or
// an idle result with all fields zero. The refresh scan visits ten symbols of a
// line, then the next of the four lines, one slot per transfer; a symbol's dirty
// mark is cleared only when the panel accepts the write reported in the same
// transfer. The core takes one transfer per clock cycle when the output side
// keeps up. An item waits in the two-entry queue behind the front, passes the
// execute stage behind the registered read of the symbol store, and its result
// is then presented from the output register. Input is accepted while the queue
// has room, so a stalled output only backs up into the input after the queue,
// the execute stage and the output register have filled. There is no clearing
// pass after reset: unwritten symbols read as zero through per-row valid bits,
// and all dirty marks start set.
`include "dual_text_display_shadow_refresh_core_assert.svh"

module dual_text_display_shadow_refresh_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] bus_byte, [8] panel_accepts, rest zero
  input  logic [2:0]  s_axis_tuser_i,   // [1:0] op, [2] display_sel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [6:0] panel_column, [8:7] panel_page,
                                        // [16:9] glyph_b0, [24:17] glyph_b1,
                                        // [32:25] glyph_b2, [40:33] glyph_b3,
                                        // [48:41] glyph_b4, rest zero
  output logic [0:0]  m_axis_tuser_o    // [0] put_valid
);

  logic                  push;
  logic                  pop;
  dtdsr_pkg::work_t      push_work;
  dtdsr_pkg::work_t      head_work;
  dtdsr_pkg::fifo_stat_t fifo_stat;

  // Views of the presented result for the checks below.
  logic                  out_idle;
  logic                  out_glyph;
  logic [1:0]            out_page;

  assign out_idle  = m_axis_tvalid_o && !m_axis_tuser_o[0];
  assign out_glyph = m_axis_tvalid_o && m_axis_tuser_o[0];
  assign out_page  = m_axis_tdata_o[8:7];

  // Front: decodes bus accesses, tracks cursors and the scan slot.
  dtdsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .work_o          (push_work)
  );

  // Queue that lets the front keep accepting while the output stalls briefly.
  dtdsr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_work),
    .pop_i       (pop),
    .head_o      (head_work),
    .stat_o      (fifo_stat)
  );

  // Back: symbol store update, dirty tracking and glyph output.
  dtdsr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_work),
    .fifo_stat_i     (fifo_stat),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // An idle result carries all-zero fields.
  `DTDSR_ASSERT(a_idle_zero, out_idle |-> m_axis_tdata_o == '0, "idle result carries data")

  // A glyph write always targets page one or two, never page zero or three.
  `DTDSR_ASSERT_NEVER(a_page_range, out_glyph && out_page[0] == out_page[1], "bad glyph page")

  // The queue can only fill up through an input transfer.
  `DTDSR_ASSERT(a_fill_by_push, $rose(fifo_stat.full) |-> $past(push), "queue filled without push")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the dual text display shadow refresh core.
// Depends on dtdsr_pkg and dual_text_display_shadow_refresh_core; needs no files.
// A directed table and then random bus traffic; every result is checked field by field.
`timescale 1ns / 1ps

module testbench;
  import dtdsr_pkg::*;

  // The spare op encoding has no enum member; the core treats it as no access.
  localparam logic [1:0] OpSpare = 2'd3;
  localparam int RandomItems = 550;
  localparam int PressureAt  = 250;
  localparam int DrainCycles = 12;

  // One glyph write to the panel, or the all-zero idle result.
  typedef struct packed {
    logic                  put;
    logic [PanelColW-1:0]  col;
    logic [PageW-1:0]      page;
    logic [4:0][7:0]       bytes;
  } glyph_t;

  // A directed row: one bus access plus the panel accept flag. Where has_exp is set,
  // the expected result is typed in; otherwise it comes from the predictor.
  typedef struct packed {
    logic [1:0] op;
    logic       sel;
    logic [7:0] data;
    logic       acc;
    logic       has_exp;
    glyph_t     exp;
  } stim_row_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_CHOKE
  } rx_mode_e;

  localparam int DirRows = 20;

  // After reset every mark is set, so the first slots of line 0 are written with
  // zero bytes and the cleared or kept marks show up later in the scan.
  localparam stim_row_t DirTable [DirRows] = '{
    '{OP_NONE, 1'b0, 8'h00, 1'b1, 1'b1, '{1'b1, 7'd60, 2'd1, 40'h0}},
    '{OpSpare, 1'b1, 8'hFF, 1'b0, 1'b1, '{1'b1, 7'd66, 2'd1, 40'h0}},
    // Command byte without bit 7: ignored.
    '{OP_CMD,  1'b0, 8'h7F, 1'b1, 1'b1, '{1'b1, 7'd72, 2'd1, 40'h0}},
    // Data equal to the stored byte: no new dirty mark.
    '{OP_DATA, 1'b0, 8'h00, 1'b1, 1'b1, '{1'b1, 7'd78, 2'd1, 40'h0}},
    '{OP_DATA, 1'b0, 8'hFF, 1'b1, 1'b0, '0},
    '{OP_CMD,  1'b0, 8'hC0, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b0, 8'hA5, 1'b0, 1'b0, '0},
    // Display 1, line 1, last column: the cursor wraps to column 0 afterwards.
    '{OP_CMD,  1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b1, 8'h5A, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b1, 8'h01, 1'b1, 1'b0, '0},
    // Column 50 lies in a group that the scan never reaches.
    '{OP_CMD,  1'b1, 8'hB2, 1'b0, 1'b0, '0},
    '{OP_DATA, 1'b1, 8'h77, 1'b1, 1'b0, '0},
    '{OP_CMD,  1'b0, 8'h80, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b0, 8'h80, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b0, 8'h7F, 1'b0, 1'b0, '0},
    '{OP_CMD,  1'b1, 8'h00, 1'b1, 1'b0, '0},
    '{OP_DATA, 1'b1, 8'hFE, 1'b1, 1'b0, '0},
    '{OP_NONE, 1'b1, 8'hFF, 1'b1, 1'b0, '0},
    '{OpSpare, 1'b0, 8'h00, 1'b1, 1'b0, '0},
    '{OP_NONE, 1'b0, 8'h55, 1'b0, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;

  dual_text_display_shadow_refresh_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow copy of the core's state, updated once per accepted input transfer.
  logic [7:0]      shadow_mem [NumLines*LineBytes];
  bit              dirty_mark [NumRows];
  bit              line_sel_q [2];
  logic [ColW-1:0] cursor_q   [2];
  int              scan_sym_q;
  logic [1:0]      scan_line_q;

  glyph_t glyph_q [$];
  int     errors = 0;

  int       burst_left = 0;
  int       rx_cnt = 0;
  rx_mode_e rx_mode = RX_OPEN;

  task automatic clear_shadow();
    for (int i = 0; i < NumLines*LineBytes; i++) shadow_mem[i] = '0;
    for (int i = 0; i < NumRows; i++) dirty_mark[i] = 1'b1;
    for (int i = 0; i < 2; i++) begin
      line_sel_q[i] = 1'b0;
      cursor_q[i]   = '0;
    end
    scan_sym_q  = 0;
    scan_line_q = '0;
  endtask

  // Applies the bus access first and then checks the current refresh slot, so a byte
  // written in this transfer is already seen by the glyph it lands in.
  function automatic glyph_t refresh_step(input logic [1:0] op, input logic sel,
                                          input logic [7:0] b, input logic acc);
    glyph_t r;
    int     ln;
    int     col;
    int     row;
    int     sym;
    int     cidx;
    r = '0;
    case (op)
      OP_CMD: begin
        if (b[CmdValidBit]) begin
          line_sel_q[sel] = b[CmdLineBit];
          cursor_q[sel]   = b[ColW-1:0];
        end
      end
      OP_DATA: begin
        col = int'(cursor_q[sel]);
        ln  = int'(sel) * 2 + int'(line_sel_q[sel]);
        if (col < LineBytes) begin
          if (shadow_mem[ln*LineBytes + col] != b)
            dirty_mark[ln*GroupsPerLine + col/SymbolCols] = 1'b1;
          shadow_mem[ln*LineBytes + col] = b;
        end
        cursor_q[sel] = ColW'(col + 1);
      end
      default: ;
    endcase

    sym = scan_sym_q;
    ln  = int'(scan_line_q);
    if (sym < GroupsPerLine) begin
      row = ln*GroupsPerLine + sym;
      if (dirty_mark[row]) begin
        r.put  = 1'b1;
        r.col  = PanelColW'(sym*SymbolPitch + ((ln >= 2) ? 0 : Display0Offset));
        r.page = PageW'(ln % 2 + 1);
        for (int k = 0; k < SymbolCols; k++) begin
          cidx = sym*SymbolCols + k;
          r.bytes[k] = (cidx < LineBytes) ? shadow_mem[ln*LineBytes + cidx] : 8'h00;
        end
        if (acc) dirty_mark[row] = 1'b0;
      end
    end

    sym++;
    if (sym >= ScannedSymbols) begin
      sym = 0;
      scan_line_q = scan_line_q + 2'd1;
    end
    scan_sym_q = sym;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, exp);
    errors++;
  endtask

  // Sender pacing: bursts of random length, separated by random gaps. A gap of zero
  // leaves tvalid high, which gives long stretches with no idling at all.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Drives one input transfer, waits for its handshake and records what it should cause.
  task automatic send_item(input logic [1:0] op, input logic sel, input logic [7:0] b,
                           input logic acc, input logic has_exp, input glyph_t exp);
    glyph_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, acc, b};
    s_tuser  <= {sel, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pred = refresh_step(op, sel, b, acc);
    glyph_q.push_back(has_exp ? exp : pred);
  endtask

  // Receiver: at the end of each period of the cycle counter the stall pattern is drawn
  // anew among always ready, coin flips and two sparse patterns, the second sparser.
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 64 == 63) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_cnt % 4 == 0);
      default:   m_tready <= (rx_cnt % 16 == 0);
    endcase
  end

  // Every output transfer is compared with the oldest expected glyph.
  always @(posedge clk_i) begin
    glyph_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (glyph_q.size() == 0) begin
        report("unexpected result, tdata", 64'(m_tdata), 64'h0);
      end else begin
        e = glyph_q.pop_front();
        if (m_tuser[0] !== e.put) report("put_valid", 64'(m_tuser[0]), 64'(e.put));
        if (m_tdata[6:0] !== e.col) report("panel_column", 64'(m_tdata[6:0]), 64'(e.col));
        if (m_tdata[8:7] !== e.page) report("panel_page", 64'(m_tdata[8:7]), 64'(e.page));
        for (int k = 0; k < SymbolCols; k++) begin
          if (m_tdata[9 + 8*k +: 8] !== e.bytes[k])
            report($sformatf("glyph_b%0d", k), 64'(m_tdata[9 + 8*k +: 8]), 64'(e.bytes[k]));
        end
      end
    end
  end

  initial begin
    int         roll;
    int         run_left;
    logic       run_sel;
    logic [1:0] op;
    logic       sel;
    logic [7:0] b;
    logic       acc;
    int         ln;
    run_left = 0;
    run_sel  = 1'b0;
    clear_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTable[i]) begin
      pace();
      send_item(DirTable[i].op, DirTable[i].sel, DirTable[i].data, DirTable[i].acc,
                DirTable[i].has_exp, DirTable[i].exp);
    end

    // Random part: mostly a cursor command followed by a run of data bytes on the
    // same display, mixed with idle slots, the spare op, ignored commands and stray data.
    for (int n = 0; n < RandomItems; n++) begin
      if (n == PressureAt) begin
        // Hold the input until every expected result has come out.
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (glyph_q.size() != 0);
      end
      roll = $urandom_range(0, 99);
      sel  = 1'($urandom_range(0, 1));
      b    = 8'($urandom);
      if (run_left > 0) begin
        op  = OP_DATA;
        sel = run_sel;
        run_left--;
      end else if (roll < 40) begin
        op = OP_CMD;
        b[CmdValidBit] = 1'b1;
        run_left = $urandom_range(1, 12);
        run_sel  = sel;
      end else if (roll < 60) begin
        op = OP_NONE;
      end else if (roll < 70) begin
        op = OpSpare;
      end else if (roll < 80) begin
        op = OP_CMD;
        b[CmdValidBit] = 1'b0;
      end else begin
        op = OP_DATA;
      end
      // Now and then rewrite the byte already stored so that no dirty mark is raised.
      if (op == OP_DATA && $urandom_range(0, 4) == 0) begin
        ln = int'(sel) * 2 + int'(line_sel_q[sel]);
        b  = shadow_mem[ln*LineBytes + int'(cursor_q[sel])];
      end
      acc = ($urandom_range(0, 9) < 7);
      pace();
      send_item(op, sel, b, acc, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (glyph_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && glyph_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== dual_text_display_shadow_refresh_core.f =====
+incdir+rtl
rtl/dtdsr_pkg.sv
rtl/dtdsr_front.sv
rtl/dtdsr_fifo.sv
rtl/dtdsr_back.sv
rtl/dual_text_display_shadow_refresh_core.sv
tb/testbench.sv
